// ===== hw/rtl/plm_pkg.sv =====
// plm_pkg: shared types and codes for the pooled linked list manager
// holds the request/response payload structs and the controller-datapath command and status
// no dependencies
`timescale 1ns / 1ps

package plm_pkg;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  position;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  result_index;
      logic [31:0] value_out;
   } rsp_type;

   // operation codes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_ERASE  = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_NOSUCC = 2'd2;

   // link store read address select
   localparam logic [1:0] LRA_POS  = 2'd0;
   localparam logic [1:0] LRA_FREE = 2'd1;
   localparam logic [1:0] LRA_LINK = 2'd2;

   // value store read address select
   localparam logic VRA_POS  = 1'b0;
   localparam logic VRA_LINK = 1'b1;

   // link store update select
   localparam logic [2:0] WR_NONE      = 3'd0;
   localparam logic [2:0] WR_INS_FRESH = 3'd1;
   localparam logic [2:0] WR_INS_POS   = 3'd2;
   localparam logic [2:0] WR_ERA_POS   = 3'd3;
   localparam logic [2:0] WR_ERA_GONE  = 3'd4;

   // response kinds
   localparam logic [2:0] RES_NONE   = 3'd0;
   localparam logic [2:0] RES_FULL   = 3'd1;
   localparam logic [2:0] RES_NOSUCC = 3'd2;
   localparam logic [2:0] RES_INSERT = 3'd3;
   localparam logic [2:0] RES_ERASE  = 3'd4;
   localparam logic [2:0] RES_READ   = 3'd5;

   typedef struct packed {
      logic       capture;
      logic       clr_write;
      logic       link_rd_en;
      logic [1:0] link_rd_sel;
      logic       val_rd_en;
      logic       val_rd_sel;
      logic       save_d1;
      logic [2:0] wr_sel;
      logic       res_set;
      logic [2:0] res_kind;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       in_range;
      logic       free_ok;
      logic       link_zero;
      logic       clear_last;
      logic       rsp_free;
   } stat_type;

endpackage

// ===== hw/rtl/plm_ram.sv =====
// plm_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module plm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/plm_ctrl.sv =====
// plm_ctrl: sequencing state machine for the pooled linked list manager
// depends on plm_pkg for the command and status structs and operation codes
`timescale 1ns / 1ps

module plm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plm_pkg::stat_type stat,
   output plm_pkg::cmd_type  cmd
);

   import plm_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RD1   = 3'd2;
   localparam logic [2:0] S_RD2   = 3'd3;
   localparam logic [2:0] S_WR1   = 3'd4;
   localparam logic [2:0] S_WR2   = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.link_rd_sel = LRA_POS;
      cmd.val_rd_sel = VRA_POS;
      cmd.wr_sel = WR_NONE;
      cmd.res_kind = RES_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            cmd.res_set = 1'b1;
            state_in = S_RESP;
            case (stat.mode)
               MODE_INSERT: begin
                  if (!stat.in_range || !stat.free_ok) begin
                     cmd.res_kind = RES_FULL;
                  end else begin
                     cmd.res_set = 1'b0;
                     cmd.link_rd_en = 1'b1;
                     state_in = S_RD2;
                  end
               end
               MODE_ERASE: begin
                  if (!stat.in_range) begin
                     cmd.res_kind = RES_NOSUCC;
                  end else begin
                     cmd.res_set = 1'b0;
                     cmd.link_rd_en = 1'b1;
                     state_in = S_RD2;
                  end
               end
               MODE_READ: begin
                  if (stat.in_range) begin
                     cmd.res_set = 1'b0;
                     cmd.link_rd_en = 1'b1;
                     cmd.val_rd_en = 1'b1;
                     state_in = S_RD2;
                  end
               end
               default: begin
                  cmd.res_kind = RES_NONE;
               end
            endcase
         end
         S_RD2: begin
            cmd.save_d1 = 1'b1;
            case (stat.mode)
               MODE_INSERT: begin
                  cmd.link_rd_en = 1'b1;
                  cmd.link_rd_sel = LRA_FREE;
                  state_in = S_WR1;
               end
               MODE_ERASE: begin
                  if (stat.link_zero) begin
                     cmd.res_set = 1'b1;
                     cmd.res_kind = RES_NOSUCC;
                     state_in = S_RESP;
                  end else begin
                     // fetch the successor's link and value
                     cmd.link_rd_en = 1'b1;
                     cmd.link_rd_sel = LRA_LINK;
                     cmd.val_rd_en = 1'b1;
                     cmd.val_rd_sel = VRA_LINK;
                     state_in = S_WR1;
                  end
               end
               default: begin
                  cmd.res_set = 1'b1;
                  cmd.res_kind = RES_READ;
                  state_in = S_RESP;
               end
            endcase
         end
         S_WR1: begin
            cmd.wr_sel = (stat.mode == MODE_INSERT) ? WR_INS_FRESH : WR_ERA_POS;
            state_in = S_WR2;
         end
         S_WR2: begin
            cmd.res_set = 1'b1;
            if (stat.mode == MODE_INSERT) begin
               cmd.wr_sel = WR_INS_POS;
               cmd.res_kind = RES_INSERT;
            end else begin
               cmd.wr_sel = WR_ERA_GONE;
               cmd.res_kind = RES_ERASE;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/plm_dpath.sv =====
// plm_dpath: link and value stores, free chain head, clearing counter and response register
// depends on plm_pkg and plm_ram
`timescale 1ns / 1ps

module plm_dpath #(
   parameter int POOL_SIZE  = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  plm_pkg::cmd_type  cmd,
   output plm_pkg::stat_type stat,
   input  plm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plm_pkg::rsp_type  rsp_data
);

   import plm_pkg::*;

   localparam int IDX_BITS = $clog2(POOL_SIZE);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(POOL_SIZE - 1);

   req_type              req_ff;
   logic [IDX_BITS-1:0]  free_head_ff, free_head_in;
   logic [IDX_BITS-1:0]  clr_cnt_ff;
   logic [IDX_BITS-1:0]  d1_ff;
   logic [IDX_BITS-1:0]  fresh_ff;
   logic [2:0]           res_kind_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [IDX_BITS-1:0]   pos_idx;
   logic                  link_wr_en;
   logic [IDX_BITS-1:0]   link_wr_addr, link_wr_data;
   logic [IDX_BITS-1:0]   link_rd_addr, link_rdata;
   logic                  val_wr_en;
   logic [IDX_BITS-1:0]   val_rd_addr;
   logic [VALUE_BITS-1:0] val_rdata;

   assign pos_idx = IDX_BITS'(req_ff.position);

   assign stat.mode       = req_ff.mode;
   assign stat.in_range   = ({24'd0, req_ff.position} < 32'(POOL_SIZE));
   assign stat.free_ok    = (free_head_ff != '0);
   assign stat.link_zero  = (link_rdata == '0);
   assign stat.clear_last = (clr_cnt_ff == LAST_IDX);
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.link_rd_sel)
         LRA_FREE: link_rd_addr = free_head_ff;
         LRA_LINK: link_rd_addr = link_rdata;
         default:  link_rd_addr = pos_idx;
      endcase
      val_rd_addr = (cmd.val_rd_sel == VRA_LINK) ? link_rdata : pos_idx;
   end

   always_comb begin
      link_wr_en = 1'b1;
      link_wr_addr = pos_idx;
      link_wr_data = link_rdata;
      val_wr_en = 1'b0;
      free_head_in = free_head_ff;
      if (cmd.clr_write) begin
         // reset chain: head empty, i -> i+1, last entry ends the chain
         link_wr_addr = clr_cnt_ff;
         link_wr_data = (clr_cnt_ff == '0 || clr_cnt_ff == LAST_IDX) ? '0 : clr_cnt_ff + 1'b1;
      end else begin
         case (cmd.wr_sel)
            WR_INS_FRESH: begin
               link_wr_addr = free_head_ff;
               link_wr_data = d1_ff;
               val_wr_en = 1'b1;
               free_head_in = link_rdata;
            end
            WR_INS_POS: begin
               link_wr_data = fresh_ff;
            end
            WR_ERA_POS: begin
               link_wr_data = link_rdata;
            end
            WR_ERA_GONE: begin
               link_wr_addr = d1_ff;
               link_wr_data = free_head_ff;
               free_head_in = d1_ff;
            end
            default: begin
               link_wr_en = 1'b0;
            end
         endcase
      end
   end

   plm_ram #(
      .WIDTH (IDX_BITS),
      .DEPTH (POOL_SIZE)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (cmd.link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rdata)
   );

   plm_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (POOL_SIZE)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (free_head_ff),
      .wr_data (VALUE_BITS'(req_ff.value_in)),
      .rd_en   (cmd.val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rdata)
   );

   always_comb begin
      rsp_in = '0;
      case (res_kind_ff)
         RES_FULL:   rsp_in.status = STAT_FULL;
         RES_NOSUCC: rsp_in.status = STAT_NOSUCC;
         RES_INSERT: rsp_in.result_index = 8'(fresh_ff);
         RES_ERASE: begin
            rsp_in.result_index = 8'(d1_ff);
            rsp_in.value_out = 32'(val_rdata);
         end
         RES_READ: begin
            rsp_in.result_index = 8'(d1_ff);
            rsp_in.value_out = 32'(val_rdata);
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= IDX_BITS'(1);
         clr_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         if (cmd.clr_write) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.save_d1) begin
         d1_ff <= link_rdata;
      end
      if (cmd.wr_sel == WR_INS_FRESH) begin
         fresh_ff <= free_head_ff;
      end
      if (cmd.res_set) begin
         res_kind_ff <= cmd.res_kind;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/pooled_linked_list_manager_top.sv =====
// pooled_linked_list_manager_top: top level of the pooled linked list manager
// depends on plm_pkg, plm_ctrl and plm_dpath
`timescale 1ns / 1ps

// Keeps one singly linked list and one free chain in a pool of POOL_SIZE entries, each with
// a next link and a VALUE_BITS value; entry 0 is the list head and a link of 0 ends a chain.
// Each request inserts after, erases after or reads one position and gives exactly one
// response. After reset the link store is initialised by a clearing pass over all POOL_SIZE
// entries, during which req_stall stays high. The block works on one request at a time,
// sequenced through the single read port and single write port of the link store: a read, or
// an erase with nothing after the position, passes RD1, RD2 and RESP, an insert or erase
// RD1, RD2, WR1, WR2 and RESP, and requests rejected early (pool full, position outside the
// pool, unused mode) RD1 and RESP. The response sits in an output register, so a stalled
// response only holds the block once the next request is ready to respond.
module pooled_linked_list_manager_top #(
   parameter int POOL_SIZE  = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  plm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output plm_pkg::rsp_type rsp_data
);

   import plm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   plm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   plm_dpath #(
      .POOL_SIZE  (POOL_SIZE),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/pooled_linked_list_manager_top_tb.sv =====
`timescale 1ns / 1ps
// pooled_linked_list_manager_top_tb: self-checking bench for the pooled linked list manager
// drives insert, erase, read and unused requests and checks each response against fixed values or a list model
// depends on plm_pkg and pooled_linked_list_manager_top

module pooled_linked_list_manager_top_tb;
   import plm_pkg::*;

   localparam int POOL_ENTRIES   = 256;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int GROW_ITEMS     = 340;
   localparam int DRAIN_ITEMS    = 130;
   localparam int QUIET_ITEMS    = 60;
   localparam int DIRECTED_ROWS  = 22;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  position;
      logic [31:0] value_in;
      logic        typed;
      logic [1:0]  status;
      logic [7:0]  result_index;
      logic [31:0] value_out;
   } list_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pooled_linked_list_manager_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // list model state
   logic [7:0]  next_link     [POOL_ENTRIES];
   logic [31:0] entry_value   [POOL_ENTRIES];
   bit          entry_written [POOL_ENTRIES];
   logic [7:0]  free_ptr;

   rsp_type expected_rsp_q [$];
   rsp_type row_expect = '0;
   bit      row_typed  = 1'b0;
   bit      quiet      = 1'b0;
   int      mismatches = 0;
   int      requests_taken = 0;
   int      responses_checked = 0;
   int      full_seen = 0;
   int      nosucc_seen = 0;
   int      idle_cycles = 0;
   int      rsp_hold = 0;

   // head entry first, then a worked example with fixed expected responses; untyped rows are checked by the predictor
   list_row_type directed_rows [DIRECTED_ROWS] = '{
      '{MODE_ERASE,  8'h00, 32'h0000_0000, 1'b1, STAT_NOSUCC, 8'h00, 32'h0000_0000},
      '{MODE_UNUSED, 8'h00, 32'h0000_0000, 1'b1, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_UNUSED, 8'hff, 32'hffff_ffff, 1'b1, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_INSERT, 8'h00, 32'h0000_0000, 1'b1, STAT_OK,     8'h01, 32'h0000_0000},
      '{MODE_INSERT, 8'h00, 32'hffff_ffff, 1'b1, STAT_OK,     8'h02, 32'h0000_0000},
      '{MODE_READ,   8'h02, 32'h0000_0000, 1'b1, STAT_OK,     8'h01, 32'hffff_ffff},
      '{MODE_READ,   8'h01, 32'hffff_ffff, 1'b1, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_INSERT, 8'h01, 32'ha5a5_a5a5, 1'b1, STAT_OK,     8'h03, 32'h0000_0000},
      '{MODE_ERASE,  8'h03, 32'h0000_0000, 1'b1, STAT_NOSUCC, 8'h00, 32'h0000_0000},
      '{MODE_ERASE,  8'h00, 32'h0000_0000, 1'b1, STAT_OK,     8'h02, 32'hffff_ffff},
      '{MODE_INSERT, 8'h00, 32'h5a5a_5a5a, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_ERASE,  8'h01, 32'h0000_0000, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      // freed entry keeps its value
      '{MODE_READ,   8'h03, 32'h0000_0000, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      // operations after entries that sit on the free chain
      '{MODE_INSERT, 8'hc8, 32'h1234_5678, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_ERASE,  8'hc8, 32'h0000_0000, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_INSERT, 8'hff, 32'h0000_ffff, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_ERASE,  8'hff, 32'h0000_0000, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_UNUSED, 8'h80, 32'h8000_0000, 1'b1, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_READ,   8'h02, 32'h0000_0000, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_ERASE,  8'h00, 32'h0000_0000, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_ERASE,  8'h00, 32'h0000_0000, 1'b0, STAT_OK,     8'h00, 32'h0000_0000},
      '{MODE_ERASE,  8'h00, 32'h0000_0000, 1'b1, STAT_NOSUCC, 8'h00, 32'h0000_0000}
   };

   function automatic void reset_list_state();
      for (int i = 0; i < POOL_ENTRIES; i++) begin
         next_link[i]     = (i == 0 || i == POOL_ENTRIES - 1) ? 8'd0 : 8'(i + 1);
         entry_value[i]   = '0;
         entry_written[i] = 1'b0;
      end
      free_ptr = 8'd1;
   endfunction

   // applies one operation to the list model and returns the response it gives
   function automatic rsp_type list_op_outcome(req_type r);
      rsp_type    o;
      logic [7:0] fresh;
      logic [7:0] gone;
      bit         in_pool;
      o = '0;
      in_pool = int'(r.position) < POOL_ENTRIES;
      case (r.mode)
         MODE_INSERT: begin
            if (!in_pool || free_ptr == 8'd0) begin
               o.status = STAT_FULL;
            end else begin
               fresh                 = free_ptr;
               free_ptr              = next_link[fresh];
               next_link[fresh]      = next_link[r.position];
               next_link[r.position] = fresh;
               entry_value[fresh]    = r.value_in;
               entry_written[fresh]  = 1'b1;
               o.result_index        = fresh;
            end
         end
         MODE_ERASE: begin
            gone = in_pool ? next_link[r.position] : 8'd0;
            if (gone == 8'd0) begin
               o.status = STAT_NOSUCC;
            end else begin
               next_link[r.position] = next_link[gone];
               next_link[gone]       = free_ptr;
               free_ptr              = gone;
               o.result_index        = gone;
               o.value_out           = entry_value[gone];
            end
         end
         MODE_READ: begin
            if (in_pool) begin
               o.result_index = next_link[r.position];
               o.value_out    = entry_value[r.position];
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   // true where the request would return a value that was never stored
   function automatic bit touches_unwritten(req_type r);
      logic [7:0] gone;
      gone = next_link[r.position];
      if (r.mode == MODE_READ)
         return !entry_written[r.position];
      if (r.mode == MODE_ERASE)
         return gone != 8'd0 && !entry_written[gone];
      return 1'b0;
   endfunction

   function automatic int chain_length();
      int         n;
      logic [7:0] p;
      n = 0;
      p = next_link[0];
      while (p != 8'd0 && n < POOL_ENTRIES) begin
         n++;
         p = next_link[p];
      end
      return n;
   endfunction

   // mostly positions found by walking the list, a few anywhere in the pool
   function automatic req_type draw_request(int insert_pct, int erase_pct);
      req_type    r;
      int         roll;
      int         hops;
      int         len;
      logic [7:0] p;
      len = chain_length();
      r = '0;
      for (int tries = 0; tries < 8; tries++) begin
         roll       = $urandom_range(0, 99);
         r.value_in = $urandom;
         if (roll < insert_pct)
            r.mode = MODE_INSERT;
         else if (roll < insert_pct + erase_pct)
            r.mode = MODE_ERASE;
         else if (roll < 97)
            r.mode = MODE_READ;
         else
            r.mode = MODE_UNUSED;
         if ($urandom_range(0, 99) < 7) begin
            r.position = 8'($urandom);
         end else begin
            hops = (r.mode == MODE_READ) ? $urandom_range(1, (len > 0) ? len : 1)
                                         : $urandom_range(0, len);
            p = 8'd0;
            for (int h = 0; h < hops && next_link[p] != 8'd0; h++)
               p = next_link[p];
            r.position = p;
         end
         if (!touches_unwritten(r))
            return r;
      end
      r.mode     = MODE_INSERT;
      r.position = 8'd0;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch on %s: got %0h, expected %0h (response %0d)", what, got, want,
               responses_checked);
      mismatches++;
   endtask

   // one request transfer, with an occasional idle burst before it
   task automatic send_request(input req_type item, input bit typed, input rsp_type want);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_data   <= item;
      row_typed   = typed;
      row_expect  = want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= rsp_hold - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      rsp_type predicted;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = list_op_outcome(req_data);
            expected_rsp_q.push_back(row_typed ? row_expect : predicted);
            requests_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response with nothing outstanding", got, 0);
            end else begin
               want = expected_rsp_q.pop_front();
               responses_checked++;
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.result_index != want.result_index)
                  report_mismatch("result_index", got.result_index, want.result_index);
               if (got.value_out != want.value_out)
                  report_mismatch("value_out", got.value_out, want.value_out);
               if (want.status == STAT_FULL)
                  full_seen++;
               if (want.status == STAT_NOSUCC)
                  nosucc_seen++;
            end
         end
      end
   end

   // watchdog: covers the clearing pass after reset with plenty of margin
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      list_row_type row;
      req_type      item;
      rsp_type      want;
      reset_list_state();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row                = directed_rows[i];
         item.mode          = row.mode;
         item.position      = row.position;
         item.value_in      = row.value_in;
         want.status        = row.status;
         want.result_index  = row.result_index;
         want.value_out     = row.value_out;
         send_request(item, row.typed, want);
      end

      // grow until the pool runs full, then drain it again
      for (int n = 0; n < GROW_ITEMS + DRAIN_ITEMS; n++) begin
         quiet = n >= GROW_ITEMS + DRAIN_ITEMS - QUIET_ITEMS;
         item  = (n < GROW_ITEMS) ? draw_request(88, 6) : draw_request(15, 60);
         send_request(item, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("covered %0d requests (%0d directed), %0d responses checked",
               requests_taken, DIRECTED_ROWS, responses_checked);
      $display("pool full answers %0d, erase with no successor %0d, mismatches %0d",
               full_seen, nosucc_seen, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
